/* rtl/naive_bayes_binary_classify_macros.svh */
// assertion macros shared by the naive bayes classifier rtl
`ifndef NAIVE_BAYES_BINARY_CLASSIFY_MACROS_SVH
`define NAIVE_BAYES_BINARY_CLASSIFY_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define NBBC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbbc same-cycle check failed");

// next-cycle implication
`define NBBC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbbc next-cycle check failed");

`endif

/* rtl/nbbc_pkg.sv */
// types, constants and helpers of the naive bayes classifier
`timescale 1ns / 1ps
`default_nettype none

package nbbc_pkg;

    localparam int MAX_FEATURES_DEF = 16;
    localparam int MAX_CLASSES_DEF  = 8;

    localparam int COST_W  = 16;
    localparam int SCORE_W = 21;
    localparam int LABEL_W = 16;
    localparam int CFG_W   = 16;

    localparam logic [COST_W-1:0]  COST_INFINITE = {COST_W{1'b1}};
    localparam logic [SCORE_W-1:0] SCORE_MAX     = {SCORE_W{1'b1}};

    localparam logic [3:0] CLASS_COUNT_RESET = 4'd8;

    typedef logic [SCORE_W-1:0] score_t;

    typedef enum logic [1:0] {
        CMD_LOAD_COST  = 2'd0,
        CMD_LOAD_LABEL = 2'd1,
        CMD_FEATURE    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_USE_PRIOR   = 2'd1,
        CFG_CLASS_COUNT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_ARGMAX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [5:0]         table_row;
        logic [2:0]         class_index;
        logic [15:0]        cost_value;
        logic signed [15:0] label_value;
        logic signed [15:0] feature_value;
        logic               last_feature;
    } item_t;

    typedef struct packed {
        logic signed [15:0] predicted_label;
        logic [2:0]         predicted_class;
        logic               feature_overflow;
    } result_t;

    // saturating score update, an infinite cost pins the score at the top
    function automatic score_t sat_add(input score_t score, input logic [COST_W-1:0] cost);
        logic [SCORE_W:0] sum;
        sum = {1'b0, score} + (SCORE_W+1)'(cost);
        if (cost == COST_INFINITE || sum[SCORE_W])
            return SCORE_MAX;
        return sum[SCORE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/nbbc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module nbbc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 264
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/naive_bayes_binary_classify.sv */
// naive bayes classifier over thresholded features, log-domain cost sums
//
// usage: requests arrive on the item channel (item_valid / item_stall), results leave
// on the result channel (result_valid / result_stall). load requests write the cost
// ram or the label table without leaving idle. a feature request selects a cost row
// from the threshold compare and adds that row to every class score through one
// shared saturating adder fed by the cost ram; a feature past MAX_FEATURES adds no
// row and sets the overflow flag. a feature marked last also adds the prior row when
// use_prior is set, then scans the scores one class a cycle for the lowest cost
// (class_count clamped to 1..MAX_CLASSES) and writes the result register once that
// register is free.
// item_stall is high while a request is at work. the result register is separate,
// so load and non-last feature requests continue while result_stall holds a
// result; a last feature waits until the register frees.
// reset clears the scores, the feature position, the overflow flag and the config
// registers (threshold 0, use_prior 0, class_count 8); the cost and label tables
// hold nothing defined until loaded. config writes land at once, so they belong
// only in idle time with no request at work.
`timescale 1ns / 1ps
`default_nettype none
`include "naive_bayes_binary_classify_macros.svh"

module naive_bayes_binary_classify #(
    parameter int MAX_FEATURES = nbbc_pkg::MAX_FEATURES_DEF,
    parameter int MAX_CLASSES  = nbbc_pkg::MAX_CLASSES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic [1:0]                cfg_index,
    input  wire logic [nbbc_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                      item_valid,
    output logic                           item_stall,
    input  wire nbbc_pkg::item_t           item,
    output logic                           result_valid,
    input  wire logic                      result_stall,
    output nbbc_pkg::result_t              result
);

    localparam int COST_ROWS = 2 * MAX_FEATURES + 1;
    localparam int PRIOR_ROW = 2 * MAX_FEATURES;
    localparam int DEPTH     = COST_ROWS * MAX_CLASSES;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int ROW_W     = $clog2(COST_ROWS);
    localparam int IDX_W     = $clog2(MAX_CLASSES);
    localparam int CNT_W     = $clog2(MAX_CLASSES + 1);
    localparam int POS_W     = $clog2(MAX_FEATURES + 1);

    nbbc_pkg::state_t state_reg, state_next;

    logic signed [15:0]  threshold_reg;
    logic                use_prior_reg;
    logic [3:0]          class_count_reg;

    nbbc_pkg::score_t    scores_reg [MAX_CLASSES];
    nbbc_pkg::score_t    scores_next [MAX_CLASSES];
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                overflow_reg, overflow_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [CNT_W-1:0]    step_reg, step_next;
    logic                last_reg, last_next;
    logic                prior_pass_reg, prior_pass_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    nbbc_pkg::score_t    best_score_reg, best_score_next;

    logic [nbbc_pkg::LABEL_W-1:0] label_reg [MAX_CLASSES];
    logic                label_we;
    logic [IDX_W-1:0]    label_waddr;

    logic                result_valid_reg;
    nbbc_pkg::result_t   result_reg;
    logic                result_load;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [nbbc_pkg::COST_W-1:0] ram_rdata;

    logic                item_fire;
    logic                feature_bin;
    logic                load_ok;
    logic [CNT_W-1:0]    class_limit;
    logic [IDX_W-1:0]    add_idx;
    logic [IDX_W-1:0]    scan_idx;

    nbbc_ram #(
        .WIDTH(nbbc_pkg::COST_W),
        .DEPTH(DEPTH)
    ) u_cost_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(item.cost_value),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign item_stall   = (state_reg != nbbc_pkg::ST_IDLE);
    assign item_fire    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign feature_bin = (item.feature_value > threshold_reg);
    assign load_ok     = (int'(item.table_row) < COST_ROWS) &&
                         (int'(item.class_index) < MAX_CLASSES);
    assign add_idx     = IDX_W'(step_reg - CNT_W'(1));
    assign scan_idx    = step_reg[IDX_W-1:0];
    assign ram_raddr   = ADDR_W'(row_reg) * ADDR_W'(MAX_CLASSES) + ADDR_W'(scan_idx);
    assign ram_waddr   = ADDR_W'(item.table_row) * ADDR_W'(MAX_CLASSES) +
                         ADDR_W'(item.class_index);
    assign label_waddr = IDX_W'(item.class_index);

    // zero acts as one, above the class bound acts as the bound
    always_comb
    begin
        if (class_count_reg == 4'd0)
            class_limit = CNT_W'(1);
        else if (int'(class_count_reg) > MAX_CLASSES)
            class_limit = CNT_W'(MAX_CLASSES);
        else
            class_limit = CNT_W'(class_count_reg);
    end

    always_comb
    begin
        state_next      = state_reg;
        scores_next     = scores_reg;
        pos_next        = pos_reg;
        overflow_next   = overflow_reg;
        row_next        = row_reg;
        step_next       = step_reg;
        last_next       = last_reg;
        prior_pass_next = prior_pass_reg;
        best_idx_next   = best_idx_reg;
        best_score_next = best_score_reg;
        ram_we          = 1'b0;
        label_we        = 1'b0;
        result_load     = 1'b0;

        unique case (state_reg)
            nbbc_pkg::ST_IDLE:
            begin
                if (item_fire)
                begin
                    unique case (item.command)
                        nbbc_pkg::CMD_LOAD_COST:
                        begin
                            ram_we = load_ok;
                        end
                        nbbc_pkg::CMD_LOAD_LABEL:
                        begin
                            label_we = (int'(item.class_index) < MAX_CLASSES);
                        end
                        nbbc_pkg::CMD_FEATURE:
                        begin
                            last_next       = item.last_feature;
                            prior_pass_next = 1'b0;
                            step_next       = '0;
                            if (int'(pos_reg) < MAX_FEATURES)
                            begin
                                row_next   = ROW_W'({pos_reg, feature_bin});
                                pos_next   = pos_reg + POS_W'(1);
                                state_next = nbbc_pkg::ST_ACCUM;
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                                if (item.last_feature && use_prior_reg)
                                begin
                                    row_next        = ROW_W'(PRIOR_ROW);
                                    prior_pass_next = 1'b1;
                                    state_next      = nbbc_pkg::ST_ACCUM;
                                end
                                else if (item.last_feature)
                                begin
                                    state_next = nbbc_pkg::ST_ARGMAX;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            nbbc_pkg::ST_ACCUM:
            begin
                // read of class k issued at step k, its sum lands at step k+1
                if (step_reg != '0)
                begin
                    scores_next[add_idx] = nbbc_pkg::sat_add(scores_reg[add_idx], ram_rdata);
                end
                if (step_reg == CNT_W'(MAX_CLASSES))
                begin
                    step_next = '0;
                    if (last_reg && use_prior_reg && !prior_pass_reg)
                    begin
                        row_next        = ROW_W'(PRIOR_ROW);
                        prior_pass_next = 1'b1;
                    end
                    else if (last_reg)
                    begin
                        state_next = nbbc_pkg::ST_ARGMAX;
                    end
                    else
                    begin
                        state_next = nbbc_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + CNT_W'(1);
                end
            end

            nbbc_pkg::ST_ARGMAX:
            begin
                if (step_reg == '0)
                begin
                    best_idx_next   = '0;
                    best_score_next = scores_reg[0];
                    step_next       = CNT_W'(1);
                end
                else if (step_reg < class_limit)
                begin
                    // strict compare keeps the lowest index on ties
                    if (scores_reg[scan_idx] < best_score_reg)
                    begin
                        best_idx_next   = scan_idx;
                        best_score_next = scores_reg[scan_idx];
                    end
                    step_next = step_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = nbbc_pkg::ST_DONE;
                end
            end

            nbbc_pkg::ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_load   = 1'b1;
                    for (int k = 0; k < MAX_CLASSES; k++)
                    begin
                        scores_next[k] = '0;
                    end
                    pos_next      = '0;
                    overflow_next = 1'b0;
                    step_next     = '0;
                    state_next    = nbbc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = nbbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nbbc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CLASSES; k++)
            begin
                scores_reg[k] <= '0;
            end
            pos_reg          <= '0;
            overflow_reg     <= 1'b0;
            step_reg         <= '0;
            last_reg         <= 1'b0;
            prior_pass_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            threshold_reg    <= '0;
            use_prior_reg    <= 1'b0;
            class_count_reg  <= nbbc_pkg::CLASS_COUNT_RESET;
        end
        else
        begin
            scores_reg     <= scores_next;
            pos_reg        <= pos_next;
            overflow_reg   <= overflow_next;
            step_reg       <= step_next;
            last_reg       <= last_next;
            prior_pass_reg <= prior_pass_next;
            if (result_load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                case (cfg_index)
                    nbbc_pkg::CFG_THRESHOLD:   threshold_reg   <= signed'(cfg_data);
                    nbbc_pkg::CFG_USE_PRIOR:   use_prior_reg   <= cfg_data[0];
                    nbbc_pkg::CFG_CLASS_COUNT: class_count_reg <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        best_idx_reg   <= best_idx_next;
        best_score_reg <= best_score_next;
        if (label_we)
        begin
            label_reg[label_waddr] <= item.label_value;
        end
        if (result_load)
        begin
            result_reg.predicted_label  <= signed'(label_reg[best_idx_reg]);
            result_reg.predicted_class  <= 3'(best_idx_reg);
            result_reg.feature_overflow <= overflow_reg;
        end
    end

    `NBBC_ASSERT_NOW(a_accum_row_in_range, state_reg == nbbc_pkg::ST_ACCUM,
        int'(row_reg) < COST_ROWS)
    `NBBC_ASSERT_NOW(a_best_tracks_score,
        state_reg == nbbc_pkg::ST_ARGMAX && step_reg != '0,
        best_score_reg == scores_reg[best_idx_reg])
    `NBBC_ASSERT_NOW(a_best_behind_scan,
        state_reg == nbbc_pkg::ST_ARGMAX && step_reg != '0,
        CNT_W'(best_idx_reg) < step_reg)
    `NBBC_ASSERT_NEXT(a_done_clears_sample, result_load,
        result_valid_reg && pos_reg == '0 && !overflow_reg &&
        state_reg == nbbc_pkg::ST_IDLE)

endmodule

`default_nettype wire

/* tb/tb_naive_bayes_binary_classify.sv */
// self-checking testbench for the naive bayes binary classifier
`timescale 1ns / 1ps

module tb_naive_bayes_binary_classify;
    import nbbc_pkg::*;

    localparam int PRIOR_ROW       = 2 * MAX_FEATURES_DEF;
    localparam int NUM_CLASSES     = MAX_CLASSES_DEF;
    localparam int TARGET_REQUESTS = 650;
    localparam int PHASE_REQUESTS  = 50;
    localparam int IDLE_CYCLES     = 48;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int NUM_STEPS       = 22;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one directed step: value goes to cost, label and feature alike,
    // repeated loads walk the class index, repeated features end on the last one
    typedef struct packed {
        logic [1:0]  cmd;
        logic [5:0]  row;
        logic [2:0]  cls;
        logic [15:0] value;
        logic [4:0]  reps;
        logic        last;
        logic        typed;
        result_t     want;
    } step_t;

    // fill: every cost 1.0, label of class k is 1000 * k - 3500
    localparam step_t DIRECTED_STEPS [NUM_STEPS] = '{
        // all classes tie, lowest index wins
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd0,    5'd1,  1'b1, 1'b1, '{-16'sd3500, 3'd0, 1'b0}},
        '{CMD_LOAD_LABEL, 6'd0,  3'd0, 16'h8000, 5'd1,  1'b0, 1'b0, '0},
        '{CMD_LOAD_LABEL, 6'd0,  3'd7, 16'h7fff, 5'd1,  1'b0, 1'b0, '0},
        '{CMD_LOAD_COST,  6'd1,  3'd7, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'h7fff, 5'd1,  1'b1, 1'b1, '{16'sd32767, 3'd7, 1'b0}},
        // equal to the threshold still picks bin 0
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd0,    5'd1,  1'b1, 1'b1, '{-16'sd32768, 3'd0, 1'b0}},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd1,    5'd1,  1'b1, 1'b0, '0},
        // zero probability for class 0
        '{CMD_LOAD_COST,  6'd0,  3'd0, 16'hffff, 5'd1,  1'b0, 1'b0, '0},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'h8000, 5'd1,  1'b1, 1'b1, '{-16'sd2500, 3'd1, 1'b0}},
        // rows past the prior row are dropped, unused command does nothing
        '{CMD_LOAD_COST,  6'd33, 3'd3, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_LOAD_COST,  6'd63, 3'd7, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_UNUSED,     6'd63, 3'd7, 16'hffff, 5'd1,  1'b1, 1'b0, '0},
        // one feature past the bound, then exactly the bound
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd1,    5'd17, 1'b1, 1'b1, '{16'sd32767, 3'd7, 1'b1}},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'hfffb, 5'd16, 1'b1, 1'b1, '{-16'sd2500, 3'd1, 1'b0}},
        // cost load in the middle of a sample
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_LOAD_COST,  6'd2,  3'd3, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd0,    5'd1,  1'b1, 1'b1, '{-16'sd500, 3'd3, 1'b0}},
        '{CMD_LOAD_COST,  6'd32, 3'd6, 16'd0,    5'd1,  1'b0, 1'b0, '0},
        '{CMD_LOAD_COST,  6'd3,  3'd2, 16'hfffe, 5'd1,  1'b0, 1'b0, '0},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd100,  5'd2,  1'b1, 1'b0, '0},
        // every class at zero probability ties at the top
        '{CMD_LOAD_COST,  6'd4,  3'd0, 16'hffff, 5'd8,  1'b0, 1'b0, '0},
        '{CMD_FEATURE,    6'd0,  3'd0, 16'd0,    5'd3,  1'b1, 1'b1, '{-16'sd32768, 3'd0, 1'b0}}
    };

    logic         clk;
    logic         rst_n;
    logic         cfg_write;
    logic [1:0]   cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic         item_valid;
    logic         item_stall;
    item_t        item;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_t      result;

    // classifier state as predicted
    logic [15:0]        cost_mem [0:PRIOR_ROW][0:NUM_CLASSES-1];
    logic [15:0]        label_mem [0:NUM_CLASSES-1];
    score_t             score_acc [0:NUM_CLASSES-1];
    int unsigned        feature_pos;
    bit                 overflow_flag;
    logic signed [15:0] thr_reg;
    bit                 prior_reg;
    logic [3:0]         classes_reg;

    result_t     pending_results [$];
    int          burst_left = 0;
    int          requests_sent = 0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    naive_bayes_binary_classify dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_cost_row(input int row);
        logic [SCORE_W:0] sum;
        for (int k = 0; k < NUM_CLASSES; k++)
        begin
            sum = {1'b0, score_acc[k]} + (SCORE_W+1)'(cost_mem[row][k]);
            if (cost_mem[row][k] == COST_INFINITE || sum > SCORE_MAX)
                score_acc[k] = SCORE_MAX;
            else
                score_acc[k] = sum[SCORE_W-1:0];
        end
    endfunction

    // advances the predicted state, returns 1 when the request yields a label
    function automatic bit classify(input item_t req, output result_t res);
        int best;
        int n;
        res = '0;
        case (req.command)
            CMD_LOAD_COST:
            begin
                if (req.table_row <= PRIOR_ROW)
                    cost_mem[req.table_row][req.class_index] = req.cost_value;
                return 1'b0;
            end
            CMD_LOAD_LABEL:
            begin
                label_mem[req.class_index] = req.label_value;
                return 1'b0;
            end
            CMD_FEATURE: ;
            default: return 1'b0;
        endcase
        if (feature_pos < MAX_FEATURES_DEF)
        begin
            add_cost_row(2 * feature_pos + (($signed(req.feature_value) > thr_reg) ? 1 : 0));
            feature_pos++;
        end
        else
            overflow_flag = 1'b1;
        if (!req.last_feature)
            return 1'b0;
        if (prior_reg)
            add_cost_row(PRIOR_ROW);
        n = int'(classes_reg);
        if (n < 1)
            n = 1;
        if (n > NUM_CLASSES)
            n = NUM_CLASSES;
        best = 0;
        for (int k = 1; k < n; k++)
            if (score_acc[k] < score_acc[best])
                best = k;
        res.predicted_label  = label_mem[best];
        res.predicted_class  = 3'(best);
        res.feature_overflow = overflow_flag;
        foreach (score_acc[k])
            score_acc[k] = '0;
        feature_pos   = 0;
        overflow_flag = 1'b0;
        return 1'b1;
    endfunction

    function automatic item_t random_item(input logic [1:0] cmd);
        logic [63:0] raw;
        item_t       r;
        raw = {$urandom, $urandom};
        r = raw[$bits(item_t)-1:0];
        r.command = cmd;
        return r;
    endfunction

    task automatic send_item(input item_t req, input bit typed, input result_t want);
        result_t got;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        burst_left--;
        requests_sent++;
        if (classify(req, got))
            pending_results.push_back(typed ? want : got);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_THRESHOLD:   thr_reg = data;
            CFG_USE_PRIOR:   prior_reg = data[0];
            CFG_CLASS_COUNT: classes_reg = data[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [15:0] thr, input logic [15:0] prior,
                              input logic [15:0] count);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_USE_PRIOR, prior);
        write_reg(CFG_CLASS_COUNT, count);
        cfg_write <= 1'b0;
    endtask

    // drain all labels, then give the block time to finish loads and features
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_random_load();
        item_t req;
        int    pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            req = random_item(CMD_LOAD_COST);
            req.table_row = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(PRIOR_ROW + 1, 63))
                                                        : 6'($urandom_range(0, PRIOR_ROW));
            case ($urandom_range(0, 7))
                0:       req.cost_value = COST_INFINITE;
                1:       req.cost_value = 16'hfffe;
                2, 3:    req.cost_value = 16'($urandom_range(0, 15));
                4:       ;
                default: req.cost_value = 16'($urandom_range(0, 1023));
            endcase
        end
        else if (pick < 9)
            req = random_item(CMD_LOAD_LABEL);
        else
            req = random_item(CMD_UNUSED);
        send_item(req, 1'b0, '0);
    endtask

    // result receiver stalls with a duty that changes every so often
    always @(posedge clk or negedge rst_n)
    begin
        static int stall_left = 0;
        static int stall_pct = 0;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 75;
                    default: stall_pct = 88;
                endcase
                stall_left = $urandom_range(16, 160);
            end
            else
                stall_left--;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: label %0d class %0d overflow %0d with none expected",
                             $time, $signed(result.predicted_label),
                             result.predicted_class, result.feature_overflow);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.predicted_label !== want.predicted_label
                    || result.predicted_class !== want.predicted_class
                    || result.feature_overflow !== want.feature_overflow)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: expected label %0d class %0d overflow %0d, got %0d %0d %0d",
                                 $time, $signed(want.predicted_label), want.predicted_class,
                                 want.feature_overflow, $signed(result.predicted_label),
                                 result.predicted_class, result.feature_overflow);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_naive_bayes_binary_classify: done, errors");
            $finish;
        end
    end

    initial
    begin
        item_t req;
        step_t st;
        int    phase;
        int    phase_start;
        int    len;
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = CFG_THRESHOLD;
        cfg_data    = '0;
        item_valid  = 1'b0;
        item        = '0;
        feature_pos   = 0;
        overflow_flag = 1'b0;
        thr_reg       = '0;
        prior_reg     = 1'b0;
        classes_reg   = CLASS_COUNT_RESET;
        foreach (score_acc[k])
            score_acc[k] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_config(16'd0, 16'd0, 16'd8);

        // every cost and label is written before any feature reads it
        for (int r = 0; r <= PRIOR_ROW; r++)
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                req = random_item(CMD_LOAD_COST);
                req.table_row   = 6'(r);
                req.class_index = 3'(c);
                req.cost_value  = 16'h0100;
                send_item(req, 1'b0, '0);
            end
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            req = random_item(CMD_LOAD_LABEL);
            req.class_index = 3'(c);
            req.label_value = 16'(1000 * c - 3500);
            send_item(req, 1'b0, '0);
        end

        for (int s = 0; s < NUM_STEPS; s++)
        begin
            st = DIRECTED_STEPS[s];
            for (int r = 0; r < st.reps; r++)
            begin
                req = '0;
                req.command       = st.cmd;
                req.table_row     = st.row;
                req.class_index   = (st.cmd == CMD_FEATURE) ? st.cls : 3'(int'(st.cls) + r);
                req.cost_value    = st.value;
                req.label_value   = st.value;
                req.feature_value = st.value;
                req.last_feature  = st.last && (r == st.reps - 1);
                send_item(req, st.typed, st.want);
            end
        end
        settle();

        phase = 0;
        while (requests_sent < TARGET_REQUESTS)
        begin
            case (phase)
                0:       set_config(16'h8000, 16'd1, 16'd0);
                1:       set_config(16'h7fff, 16'd0, 16'd15);
                2:       set_config(16'd0, 16'hfffe, 16'd1);
                3:       set_config(16'($urandom), 16'd1, 16'd8);
                4:       set_config(16'($urandom_range(0, 255)) - 16'd128, 16'd1, 16'd9);
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            phase_start = requests_sent;
            while (requests_sent - phase_start < PHASE_REQUESTS)
            begin
                repeat ($urandom_range(0, 2)) send_random_load();
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
                                                  : $urandom_range(1, 6);
                for (int f = 0; f < len; f++)
                begin
                    if ($urandom_range(0, 11) == 0)
                        send_random_load();
                    req = random_item(CMD_FEATURE);
                    case ($urandom_range(0, 7))
                        0, 1:    req.feature_value = thr_reg;
                        2, 3:    req.feature_value = thr_reg + 16'sd1;
                        4:       req.feature_value = 16'h8000;
                        5:       req.feature_value = 16'h7fff;
                        default: ;
                    endcase
                    req.last_feature = (f == len - 1);
                    send_item(req, 1'b0, '0);
                end
            end
            settle();
            phase++;
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_naive_bayes_binary_classify: done, clean");
        else
            $display("tb_naive_bayes_binary_classify: done, errors");
        $finish;
    end

endmodule
